FILE: hw/rtl/i2cmwp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the i2c master write phaser
// no dependencies

package i2cmwp_pkg;

  localparam int unsigned CMD_DEPTH_DEF = 2;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;
  localparam logic [3:0] ACK_BIT = 4'd8;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_BYTE  = 2'd2;
  localparam logic [1:0] CMD_ADDR  = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] payload;
  } in_item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic sda_released;
    logic sample_ack;
    logic last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_START,
    OP_STOP,
    OP_BYTE
  } op_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [7:0] bits;
  } cmd_req_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

endpackage

FILE: hw/rtl/i2cmwp_front.sv
`timescale 1ns / 1ps
// front end: accepts commands, classifies them and queues them for the back end
// depends on i2cmwp_pkg

module i2cmwp_front #(
  parameter int unsigned CMD_DEPTH = i2cmwp_pkg::CMD_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  i2cmwp_pkg::in_item_t in_data,
  output i2cmwp_pkg::cmd_req_t head,
  input  logic                 take
);
  import i2cmwp_pkg::*;

  localparam int unsigned PW = $clog2(CMD_DEPTH);
  localparam int unsigned CW = $clog2(CMD_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(CMD_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(CMD_DEPTH);

  op_t        op_q_r   [CMD_DEPTH];
  logic [7:0] bits_q_r [CMD_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  op_t        op_c;
  logic [7:0] bits_c;
  logic       wr_en, rd_en;

  // address goes out as bits 7..1 followed by a write bit of 0
  always_comb begin
    case (in_data.command)
      CMD_START: begin
        op_c   = OP_START;
        bits_c = in_data.payload;
      end
      CMD_STOP: begin
        op_c   = OP_STOP;
        bits_c = in_data.payload;
      end
      CMD_BYTE: begin
        op_c   = OP_BYTE;
        bits_c = in_data.payload;
      end
      default: begin
        op_c   = OP_BYTE;
        bits_c = {in_data.payload[7:1], 1'b0};
      end
    endcase
  end

  assign full  = (cnt_r == DEPTH_C);
  assign wr_en = push && !full;
  assign rd_en = take && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.op    = op_q_r[rd_ptr_r];
  assign head.bits  = bits_q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      op_q_r[wr_ptr_r]   <= op_c;
      bits_q_r[wr_ptr_r] <= bits_c;
    end
  end

endmodule

FILE: hw/rtl/i2cmwp_back.sv
`timescale 1ns / 1ps
// back end: phase sequencer, half period timer and result register
// depends on i2cmwp_pkg

module i2cmwp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  i2cmwp_pkg::cmd_req_t  head,
  output logic                  take,
  input  logic [15:0]           half_period,
  output logic                  empty,
  input  logic                  pop,
  output i2cmwp_pkg::out_item_t out_data
);
  import i2cmwp_pkg::*;

  bk_state_t state_r, state_nxt;
  op_t        op_r;
  logic [7:0] shift_r;
  logic [3:0] bit_r;
  logic [1:0] sub_r;
  logic       scl_r;
  logic [15:0] timer_r, timer_nxt;
  logic       out_valid_r;
  out_item_t  out_r, ph;
  logic       emit;

  // phase table
  always_comb begin
    ph = '0;
    case (op_r)
      OP_START: begin
        case (sub_r)
          2'd0: begin ph.scl_level = scl_r; ph.sda_level = 1'b1; end
          2'd1: begin ph.scl_level = 1'b1;  ph.sda_level = 1'b1; end
          2'd2: begin ph.scl_level = 1'b1;  ph.sda_level = 1'b0; end
          default: begin
            ph.scl_level = 1'b0;
            ph.sda_level = 1'b0;
            ph.last      = 1'b1;
          end
        endcase
      end
      OP_STOP: begin
        case (sub_r)
          2'd0: begin ph.scl_level = scl_r; ph.sda_level = 1'b0; end
          2'd1: begin ph.scl_level = 1'b1;  ph.sda_level = 1'b0; end
          default: begin
            ph.scl_level = 1'b1;
            ph.sda_level = 1'b1;
            ph.last      = 1'b1;
          end
        endcase
      end
      default: begin
        if (bit_r == ACK_BIT) begin
          // acknowledge clock, sda released and sampled with scl high
          ph.sda_level    = 1'b1;
          ph.sda_released = 1'b1;
          ph.scl_level    = (sub_r == 2'd1);
          ph.sample_ack   = (sub_r == 2'd1);
          ph.last         = (sub_r == 2'd2);
        end else begin
          ph.sda_level = shift_r[7];
          case (sub_r)
            2'd0:    ph.scl_level = scl_r;
            2'd1:    ph.scl_level = 1'b1;
            default: ph.scl_level = 1'b0;
          endcase
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (emit && ph.last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    take = 1'b0;
    emit = 1'b0;
    case (state_r)
      BK_IDLE: take = head.valid;
      BK_RUN:  emit = (timer_r == '0) && (!out_valid_r || pop);
      default: begin
        take = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    timer_nxt = timer_r;
    if (emit) begin
      timer_nxt = (half_period == '0) ? '0 : half_period - 1'b1;
    end else if (timer_r != '0) begin
      timer_nxt = timer_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      scl_r       <= 1'b1;
      timer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      timer_r <= timer_nxt;
      if (emit) begin
        scl_r       <= ph.scl_level;
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r    <= head.op;
      shift_r <= head.bits;
      bit_r   <= '0;
      sub_r   <= '0;
    end else if (emit) begin
      if (op_r == OP_BYTE && sub_r == 2'd2) begin
        sub_r   <= '0;
        bit_r   <= bit_r + 1'b1;
        shift_r <= {shift_r[6:0], 1'b0};
      end else begin
        sub_r <= sub_r + 1'b1;
      end
    end
    if (emit) begin
      out_r <= ph;
    end
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

endmodule

FILE: hw/rtl/i2c_master_write_phaser_top.sv
`timescale 1ns / 1ps
// Each command yields its bus phases one at a time: start gives 4, stop 3, and a data
// byte or address 27. A phase is put out only when the phase timer in the back end, reloaded
// from half_period_cycles at each phase, has run out and the result register is free.
// Pulling the next command from the command queue goes through the idle state of the back
// end, which the timer hides unless half_period_cycles is 0 or 1.
// Up to CMD_DEPTH commands queue in the front end while the back end is busy.
// depends on i2cmwp_pkg, i2cmwp_front, i2cmwp_back

module i2c_master_write_phaser_top #(
  parameter int unsigned CMD_DEPTH = i2cmwp_pkg::CMD_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  i2cmwp_pkg::in_item_t  in_data,
  output logic                  empty,
  input  logic                  pop,
  output i2cmwp_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data
);
  import i2cmwp_pkg::*;

  cmd_req_t    head;
  logic        take;
  logic [15:0] half_period_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_period_r <= cfg_data;
    end
  end

  i2cmwp_front #(
    .CMD_DEPTH(CMD_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .in_data(in_data),
    .head   (head),
    .take   (take)
  );

  i2cmwp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .take       (take),
    .half_period(half_period_r),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data)
  );

endmodule

FILE: hw/rtl/i2cmwp_checker.sv
`timescale 1ns / 1ps
// port level checks for the i2c master write phaser, bound to the top level
// depends on i2cmwp_pkg

module i2cmwp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  empty,
  input logic                  pop,
  input i2cmwp_pkg::out_item_t out_data
);
  import i2cmwp_pkg::*;

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result changed while waiting");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // ack is sampled only with scl high and sda released
  a_ack_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.sample_ack) |-> (out_data.scl_level && out_data.sda_released))
    else $error("ack sampled outside released high clock");

  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.sda_released) |-> out_data.sda_level)
    else $error("released sda not reading high");

endmodule

bind i2c_master_write_phaser_top i2cmwp_checker u_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .empty   (empty),
  .pop     (pop),
  .out_data(out_data)
);
